>>> hdl/ttts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttts_pkg;

	// Size of the task table and the widths that follow from it.
	localparam int MAX_TASKS = 16;
	localparam int TASK_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int WALK_W    = $clog2(MAX_TASKS + 1);

	// Stream payload widths.
	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 24;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE_RELOAD = 1'b1;

	// Reset values and period limits.
	localparam logic [7:0]  TYPE_MASK_RESET    = 8'hFF;
	localparam logic [30:0] FORCE_RELOAD_RESET = 31'd1000;
	localparam logic [15:0] PERIOD_RESET       = 16'd100;
	localparam logic [15:0] PERIOD_CAP         = 16'hFFFF;
	localparam logic [15:0] PERIOD_FALLBACK    = 16'd10;

	// Operation codes on the input tuser.
	localparam logic [2:0] OP_EXPIRE = 3'd0;
	localparam logic [2:0] OP_RUN    = 3'd1;
	localparam logic [2:0] OP_WRITE  = 3'd2;
	localparam logic [2:0] OP_SET_EN = 3'd3;
	localparam logic [2:0] OP_RELOAD = 3'd4;

	// Classified command as it sits in the queue.
	typedef enum logic [2:0] {
		CMD_EXPIRE,
		CMD_RUN,
		CMD_WRITE,
		CMD_SET_EN,
		CMD_RELOAD,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [TASK_W-1:0] idx;
		logic [31:0]       reload_value;
		logic [31:0]       start_count;
		logic              enable_flag;
		logic [2:0]        task_type;
		logic              entry_used;
	} cmd_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	// One result item.
	typedef struct packed {
		logic        kind;
		logic [3:0]  fired_index;
		logic [15:0] period;
		logic        pass_ran;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RELOAD,
		ST_WALK,
		ST_DRAIN,
		ST_CLAMP,
		ST_FIRED,
		ST_STATUS
	} state_t;

endpackage

`default_nettype wire

>>> hdl/tickless_task_timer_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Tickless task timer scheduler. The block keeps a table of sixteen periodic
// task timers and a 16-bit timer compare period. Each input item carries an
// operation on tuser: timer expired, run request, write entry, set enabled
// or reload entry. A timer expiry latches the period as pending elapsed time
// and, once the force counter has gone negative, runs a scheduling pass; a
// run request runs a pass whenever pending time is nonzero. A pass charges
// the pending time to every active entry, reports each entry that reaches
// zero and reloads it, and then sets the new period from a running minimum
// over the remaining counts of the valid entries, which the first valid
// entry seeds even at zero and only nonzero counts lower. Every input item
// yields one or more result items: one item per fired entry in ascending
// entry order (tuser 0), then a status item (tuser 1, tlast high). All of
// them carry the period in force after the whole input. A front end decodes
// and checks incoming items into a two-deep command queue, so the input
// side keeps accepting while the back end works until the queue is full;
// the back end executes one command at a time. A command without a pass
// goes straight to its status item, a reload entry through a reload step
// first. A pass takes the command, walks the table through the single read
// port of the entry memories, drains the pipeline, clamps the period, sends
// one item per fired entry and then the status item. The output register
// lets the block prepare the next item while the downstream side stalls.
// Configuration writes must only be issued while the block is idle.

module tickless_task_timer_scheduler_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             cfg_we,
	input  wire logic [ttts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ttts_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// index[3:0], reload_value[35:4], start_count[67:36], enable_flag[68],
	// task_type[71:69], entry_used[72], zero padding [79:73]
	input  wire logic [ttts_pkg::IN_DATA_W-1:0]   s_tdata,
	// op[2:0]
	input  wire logic [ttts_pkg::IN_USER_W-1:0]   s_tuser,

	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// fired_index[3:0], period[19:4], pass_ran[20], zero padding [23:21]
	output logic [ttts_pkg::OUT_DATA_W-1:0]       m_tdata,
	// kind[0]
	output logic                                  m_tuser,
	output logic                                  m_tlast
);

	logic                q_full;
	logic                push;
	ttts_pkg::cmd_t      push_cmd;
	ttts_pkg::q_head_t   head;
	logic                pop;
	ttts_pkg::out_item_t out_item;

	ttts_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ttts_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.head     (head),
		.pop      (pop)
	);

	ttts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_item  (out_item),
		.out_ready (m_tready)
	);

	// Pack the result item onto the stream.
	assign m_tdata = {3'b000, out_item.pass_ran, out_item.period, out_item.fired_index};
	assign m_tuser = out_item.kind;
	assign m_tlast = out_item.last;

endmodule

`default_nettype wire

>>> hdl/ttts_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ttts_front (
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [ttts_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic [ttts_pkg::IN_USER_W-1:0]  s_tuser,
	input  wire logic                            q_full,
	output logic                                 push,
	output ttts_pkg::cmd_t                       push_cmd
);

	logic [3:0] index;
	logic       idx_ok;

	assign index    = s_tdata[3:0];
	assign idx_ok   = 8'(index) < 8'(ttts_pkg::MAX_TASKS);
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// Table ops that address an entry outside the table become no-ops here.
	always_comb begin
		push_cmd.idx          = ttts_pkg::TASK_W'(index);
		push_cmd.reload_value = s_tdata[35:4];
		push_cmd.start_count  = s_tdata[67:36];
		push_cmd.enable_flag  = s_tdata[68];
		push_cmd.task_type    = s_tdata[71:69];
		push_cmd.entry_used   = s_tdata[72];
		unique case (s_tuser)
			ttts_pkg::OP_EXPIRE: push_cmd.kind = ttts_pkg::CMD_EXPIRE;
			ttts_pkg::OP_RUN:    push_cmd.kind = ttts_pkg::CMD_RUN;
			ttts_pkg::OP_WRITE:  push_cmd.kind = idx_ok ? ttts_pkg::CMD_WRITE : ttts_pkg::CMD_NOP;
			ttts_pkg::OP_SET_EN: push_cmd.kind = idx_ok ? ttts_pkg::CMD_SET_EN : ttts_pkg::CMD_NOP;
			ttts_pkg::OP_RELOAD: push_cmd.kind = idx_ok ? ttts_pkg::CMD_RELOAD : ttts_pkg::CMD_NOP;
			default:             push_cmd.kind = ttts_pkg::CMD_NOP;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/ttts_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none

module ttts_cmdq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ttts_pkg::cmd_t  push_cmd,
	output logic                 full,
	output ttts_pkg::q_head_t    head,
	input  wire logic            pop
);

	ttts_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full       = count_q == 2'd2;
	assign head.valid = count_q != 2'd0;
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("command popped from an empty queue");

endmodule

`default_nettype wire

>>> hdl/ttts_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ttts_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ttts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ttts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire ttts_pkg::q_head_t                 head,
	output logic                                   pop,
	output logic                                   out_valid,
	output ttts_pkg::out_item_t                    out_item,
	input  wire logic                              out_ready
);

	localparam int N = ttts_pkg::MAX_TASKS;
	localparam int TW = ttts_pkg::TASK_W;

	// Configuration.
	logic [7:0]  mask_q;
	logic [30:0] freload_q;

	// Scheduler state.
	ttts_pkg::state_t state_q, state_d;
	ttts_pkg::cmd_t   cmd_q;
	logic [N-1:0]     entry_valid_q;
	logic [N-1:0]     entry_en_q;
	logic [15:0]      pending_q;
	logic [15:0]      period_q;
	logic [32:0]      fc_q;
	logic             ran_q;
	logic [N-1:0]     fired_q;
	logic [ttts_pkg::WALK_W-1:0] walk_q;
	logic [31:0]      best_q;
	logic             have_first_q;

	// Entry storage.
	logic [2:0]  type_mem   [N];
	logic [31:0] reload_mem [N];
	logic [31:0] rem_mem    [N];

	// Walk pipeline.
	logic          go_s1;
	logic [TW-1:0] idx_s1;
	logic [2:0]    rd_type_s1;
	logic [31:0]   rd_reload_s1;
	logic [31:0]   rd_rem_s1;
	logic          go_s2;
	logic          valid_s2;
	logic [31:0]   rem_s2;

	// Output register.
	logic                out_valid_q;
	ttts_pkg::out_item_t out_item_q;

	// Combinational controls.
	logic          start_pass;
	logic          idle_pop;
	logic [TW-1:0] rd_addr;
	logic          ent_we;
	logic          rem_we;
	logic [TW-1:0] rem_wa;
	logic [31:0]   rem_wd;
	logic          out_free;
	logic          out_load;
	ttts_pkg::out_item_t out_next;
	logic          clr_fired;
	logic [TW-1:0] low_idx;

	// Stage 2 of the walk: charge pending time and decide on firing.
	logic        active_s1;
	logic [32:0] diff_s1;
	logic [31:0] sat_s1;
	logic        fire_s1;
	logic [31:0] new_rem_s1;

	assign active_s1  = go_s1 && entry_valid_q[idx_s1] && entry_en_q[idx_s1]
		&& mask_q[rd_type_s1];
	assign diff_s1    = {1'b0, rd_rem_s1} - 33'(pending_q);
	assign sat_s1     = diff_s1[32] ? 32'd0 : diff_s1[31:0];
	assign fire_s1    = active_s1 && (sat_s1 == 32'd0);
	assign new_rem_s1 = active_s1 ? (fire_s1 ? rd_reload_s1 : sat_s1) : rd_rem_s1;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		low_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (fired_q[i]) begin
				low_idx = TW'(i);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		idle_pop   = 1'b0;
		start_pass = 1'b0;
		rd_addr    = walk_q[TW-1:0];
		ent_we     = 1'b0;
		rem_we     = 1'b0;
		rem_wa     = idx_s1;
		rem_wd     = new_rem_s1;
		out_load   = 1'b0;
		clr_fired  = 1'b0;
		out_next   = '{kind: 1'b1, fired_index: 4'd0, period: period_q,
			pass_ran: ran_q, last: 1'b1};

		if (go_s1 && active_s1) begin
			rem_we = 1'b1;
		end

		unique case (state_q)
			ttts_pkg::ST_IDLE: begin
				if (head.valid) begin
					pop      = 1'b1;
					idle_pop = 1'b1;
					rd_addr  = head.cmd.idx;
					state_d  = ttts_pkg::ST_STATUS;
					case (head.cmd.kind)
						ttts_pkg::CMD_EXPIRE: begin
							if (fc_q[32] && period_q != 16'd0) begin
								start_pass = 1'b1;
							end
						end
						ttts_pkg::CMD_RUN: begin
							if (pending_q != 16'd0) begin
								start_pass = 1'b1;
							end
						end
						ttts_pkg::CMD_WRITE: begin
							ent_we = 1'b1;
							rem_we = 1'b1;
							rem_wa = head.cmd.idx;
							rem_wd = head.cmd.start_count;
						end
						ttts_pkg::CMD_RELOAD: begin
							state_d = ttts_pkg::ST_RELOAD;
						end
						default: begin
						end
					endcase
					if (start_pass) begin
						state_d = ttts_pkg::ST_WALK;
					end
				end
			end
			ttts_pkg::ST_RELOAD: begin
				rem_we  = 1'b1;
				rem_wa  = cmd_q.idx;
				rem_wd  = rd_reload_s1;
				state_d = ttts_pkg::ST_STATUS;
			end
			ttts_pkg::ST_WALK: begin
				if (walk_q == ttts_pkg::WALK_W'(N - 1)) begin
					state_d = ttts_pkg::ST_DRAIN;
				end
			end
			ttts_pkg::ST_DRAIN: begin
				if (!go_s1 && !go_s2) begin
					state_d = ttts_pkg::ST_CLAMP;
				end
			end
			ttts_pkg::ST_CLAMP: begin
				state_d = ttts_pkg::ST_FIRED;
			end
			ttts_pkg::ST_FIRED: begin
				if (fired_q == '0) begin
					state_d = ttts_pkg::ST_STATUS;
				end else if (out_free) begin
					out_load  = 1'b1;
					clr_fired = 1'b1;
					out_next  = '{kind: 1'b0, fired_index: 4'(low_idx), period: period_q,
						pass_ran: ran_q, last: 1'b0};
				end
			end
			ttts_pkg::ST_STATUS: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ttts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ttts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q        <= ttts_pkg::TYPE_MASK_RESET;
			freload_q     <= ttts_pkg::FORCE_RELOAD_RESET;
			entry_valid_q <= '0;
			entry_en_q    <= '0;
			pending_q     <= 16'd0;
			period_q      <= ttts_pkg::PERIOD_RESET;
			fc_q          <= {2'b00, ttts_pkg::FORCE_RELOAD_RESET};
			ran_q         <= 1'b0;
			fired_q       <= '0;
			walk_q        <= '0;
			best_q        <= 32'd0;
			have_first_q  <= 1'b0;
			go_s1         <= 1'b0;
			go_s2         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ttts_pkg::REG_TYPE_MASK) begin
					mask_q <= cfg_data[7:0];
				end else if (cfg_index == ttts_pkg::REG_FORCE_RELOAD) begin
					freload_q <= cfg_data[30:0];
				end
			end

			if (idle_pop) begin
				ran_q <= start_pass;
				case (head.cmd.kind)
					ttts_pkg::CMD_EXPIRE: begin
						pending_q <= period_q;
						if (fc_q[32]) begin
							fc_q <= {2'b00, freload_q};
						end else begin
							fc_q <= fc_q - 33'(period_q);
						end
					end
					ttts_pkg::CMD_WRITE: begin
						entry_valid_q[head.cmd.idx] <= head.cmd.entry_used;
						entry_en_q[head.cmd.idx]    <= head.cmd.enable_flag;
					end
					ttts_pkg::CMD_SET_EN: begin
						entry_en_q[head.cmd.idx] <= head.cmd.enable_flag;
					end
					default: begin
					end
				endcase
			end

			// Walk: issue one table read per cycle.
			if (start_pass) begin
				walk_q       <= '0;
				fired_q      <= '0;
				best_q       <= 32'd0;
				have_first_q <= 1'b0;
			end else if (state_q == ttts_pkg::ST_WALK) begin
				walk_q <= walk_q + ttts_pkg::WALK_W'(1);
			end
			go_s1 <= (state_q == ttts_pkg::ST_WALK);

			if (fire_s1) begin
				fired_q[idx_s1] <= 1'b1;
			end else if (clr_fired) begin
				fired_q[low_idx] <= 1'b0;
			end

			go_s2 <= go_s1;

			// Stage 3: running minimum, the first valid entry seeds it even at zero.
			if (go_s2 && valid_s2) begin
				if (!have_first_q) begin
					best_q       <= rem_s2;
					have_first_q <= 1'b1;
				end else if (best_q > rem_s2 && rem_s2 != 32'd0) begin
					best_q <= rem_s2;
				end
			end

			if (state_q == ttts_pkg::ST_CLAMP) begin
				pending_q <= 16'd0;
				fc_q      <= {2'b00, freload_q};
				if (best_q == 32'd0) begin
					period_q <= ttts_pkg::PERIOD_FALLBACK;
				end else if (best_q > 32'(ttts_pkg::PERIOD_CAP)) begin
					period_q <= ttts_pkg::PERIOD_CAP;
				end else begin
					period_q <= best_q[15:0];
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers and entry memories.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			type_mem[head.cmd.idx]   <= head.cmd.task_type;
			reload_mem[head.cmd.idx] <= head.cmd.reload_value;
		end
		if (rem_we) begin
			rem_mem[rem_wa] <= rem_wd;
		end
		rd_type_s1   <= type_mem[rd_addr];
		rd_reload_s1 <= reload_mem[rd_addr];
		rd_rem_s1    <= rem_mem[rd_addr];
		idx_s1       <= rd_addr;
		if (idle_pop) begin
			cmd_q <= head.cmd;
		end
		valid_s2 <= entry_valid_q[idx_s1];
		rem_s2   <= new_rem_s1;
		if (out_load) begin
			out_item_q <= out_next;
		end
	end

	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		period_q != 16'd0)
		else $error("timer period reached zero");

	a_status_after_fired: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ttts_pkg::ST_STATUS |-> fired_q == '0)
		else $error("status item reached with fired entries still pending");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_item_q.last == out_item_q.kind)
		else $error("last flag and item kind disagree");

	a_walk_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ttts_pkg::ST_IDLE |-> !go_s1 && !go_s2)
		else $error("walk pipeline busy while idle");

endmodule

`default_nettype wire

>>> tb/tb_tickless_task_timer_scheduler_core.sv
`timescale 1ns / 1ps

module tb_tickless_task_timer_scheduler_core;

	// Operation codes that the block has no use for; it must only answer them
	// with a status item.
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int    HALF_PERIOD     = 4;
	localparam int    RESET_CYCLES    = 11;
	localparam int    RANDOM_PHASES   = 5;
	localparam int    ITEMS_PER_PHASE = 60;
	localparam int    SETTLE_CYCLES   = 40;
	localparam int    HOLD_CYCLES     = 400;
	localparam int    IDLE_PCT        = 25;
	localparam int    MAX_REPORTED    = 10;
	localparam longint RUN_LIMIT_NS   = 4_000_000;

	localparam logic [15:0] RST_PERIOD = ttts_pkg::PERIOD_RESET;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [ttts_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ttts_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	// index[3:0], reload_value[35:4], start_count[67:36], enable_flag[68],
	// task_type[71:69], entry_used[72], zero padding [79:73]
	logic [ttts_pkg::IN_DATA_W-1:0]  s_tdata;
	// op[2:0]
	logic [ttts_pkg::IN_USER_W-1:0]  s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	// fired_index[3:0], period[19:4], pass_ran[20], zero padding [23:21]
	logic [ttts_pkg::OUT_DATA_W-1:0] m_tdata;
	// kind[0]
	logic                            m_tuser;
	logic                            m_tlast;

	tickless_task_timer_scheduler_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Free-running 125 MHz clock.
	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Scheduler state as this bench believes it to be. It is advanced once
	// per accepted input item and feeds the queue of awaited result items.
	logic [7:0]  mdl_type_mask;
	logic [30:0] mdl_force_reload;
	logic        slot_valid   [ttts_pkg::MAX_TASKS];
	logic        slot_enabled [ttts_pkg::MAX_TASKS];
	logic [2:0]  slot_type    [ttts_pkg::MAX_TASKS];
	logic [31:0] slot_reload  [ttts_pkg::MAX_TASKS];
	logic [31:0] slot_left    [ttts_pkg::MAX_TASKS];
	// An entry whose reload was never stored must never be reloaded.
	logic        slot_written [ttts_pkg::MAX_TASKS];
	logic [15:0] pending_ticks;
	logic [15:0] cur_period;
	logic [32:0] force_cnt;
	int          fired_slots [$];

	ttts_pkg::out_item_t awaited_reports [$];
	int                  mismatch_count = 0;

	// Knobs shared between the stimulus and the result side. When steady is
	// set neither side idles; hold_request asks the result side for one long
	// stall so that the command queue fills and s_tready drops.
	bit          steady = 1'b0;
	bit          hold_request = 1'b0;

	// Directed items. Rows with typed set carry the status item expected at a
	// glance; every other row is checked against the prediction.
	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  idx;
		logic [31:0] reload_value;
		logic [31:0] start_count;
		logic        enable_flag;
		logic [2:0]  task_type;
		logic        entry_used;
		logic        typed;
		logic [15:0] want_period;
		logic        want_ran;
	} stim_row_t;

	localparam int N_DIRECTED = 22;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// Nothing is pending after reset, so a run request must not start a pass.
		'{ttts_pkg::OP_RUN,     0, 0,            0,            0, 0, 0, 1, RST_PERIOD, 0},
		'{OP_SPARE_LO,          0, 0,            0,            0, 0, 0, 1, RST_PERIOD, 0},
		// A spare op with every field high still changes nothing.
		'{OP_SPARE_HI,         15, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 7, 1, 1, RST_PERIOD, 0},
		// Entry 0 with a zero reload fires on every pass and pins the minimum.
		'{ttts_pkg::OP_WRITE,   0, 0,            0,            1, 0, 1, 1, RST_PERIOD, 0},
		'{ttts_pkg::OP_WRITE,  15, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 7, 1, 1, RST_PERIOD, 0},
		'{ttts_pkg::OP_WRITE,   1, 50,           30,           1, 1, 1, 1, RST_PERIOD, 0},
		'{ttts_pkg::OP_WRITE,   2, 200,          70,           0, 2, 1, 1, RST_PERIOD, 0},
		// Stored but not valid: must take no part in a pass.
		'{ttts_pkg::OP_WRITE,   3, 40,           40,           1, 3, 0, 1, RST_PERIOD, 0},
		// Enabling an invalid entry only stores the bit.
		'{ttts_pkg::OP_SET_EN,  3, 0,            0,            1, 0, 0, 1, RST_PERIOD, 0},
		'{ttts_pkg::OP_SET_EN,  2, 0,            0,            1, 0, 0, 1, RST_PERIOD, 0},
		// Force counter is still positive: the expiry only latches time.
		'{ttts_pkg::OP_EXPIRE,  0, 0,            0,            0, 0, 0, 1, RST_PERIOD, 0},
		'{ttts_pkg::OP_RUN,     0, 0,            0,            0, 0, 0, 0, 0,          0},
		'{ttts_pkg::OP_RUN,     0, 0,            0,            0, 0, 0, 0, 0,          0},
		'{ttts_pkg::OP_RELOAD,  1, 0,            0,            0, 0, 0, 0, 0,          0},
		'{ttts_pkg::OP_RELOAD,  3, 0,            0,            0, 0, 0, 0, 0,          0},
		// Removing entry 0 lets the real minimum through.
		'{ttts_pkg::OP_WRITE,   0, 0,            0,            1, 0, 0, 0, 0,          0},
		'{ttts_pkg::OP_EXPIRE,  0, 0,            0,            0, 0, 0, 0, 0,          0},
		'{ttts_pkg::OP_RUN,     0, 0,            0,            0, 0, 0, 0, 0,          0},
		'{ttts_pkg::OP_SET_EN, 15, 0,            0,            0, 0, 0, 0, 0,          0},
		'{ttts_pkg::OP_WRITE,   4, 5,            1,            1, 6, 1, 0, 0,          0},
		'{ttts_pkg::OP_EXPIRE,  0, 0,            0,            0, 0, 0, 0, 0,          0},
		'{ttts_pkg::OP_RUN,     0, 0,            0,            0, 0, 0, 0, 0,          0}
	};

	// One scheduling pass over the believed state: charge pending time to the
	// active entries, collect the ones that hit zero, then derive the period.
	function automatic void run_pass();
		logic [31:0] best;
		logic        have_first;
		best = 32'd0;
		have_first = 1'b0;
		for (int i = 0; i < ttts_pkg::MAX_TASKS; i++) begin
			if (slot_valid[i] && slot_enabled[i] && mdl_type_mask[slot_type[i]]) begin
				if (slot_left[i] > {16'd0, pending_ticks})
					slot_left[i] = slot_left[i] - {16'd0, pending_ticks};
				else
					slot_left[i] = 32'd0;
				if (slot_left[i] == 32'd0) begin
					fired_slots.push_back(i);
					slot_left[i] = slot_reload[i];
				end
			end
		end
		pending_ticks = 16'd0;
		// The first valid entry seeds the minimum even when it holds zero.
		for (int i = 0; i < ttts_pkg::MAX_TASKS; i++) begin
			if (slot_valid[i]) begin
				if (!have_first) begin
					best = slot_left[i];
					have_first = 1'b1;
				end else if (best > slot_left[i] && slot_left[i] != 32'd0) begin
					best = slot_left[i];
				end
			end
		end
		if (best > {16'd0, ttts_pkg::PERIOD_CAP})
			cur_period = ttts_pkg::PERIOD_CAP;
		else
			cur_period = best[15:0];
		if (cur_period == 16'd0)
			cur_period = ttts_pkg::PERIOD_FALLBACK;
		force_cnt = {2'b00, mdl_force_reload};
	endfunction

	// Counts are mostly small so that entries fire often, with some mid-range
	// and full-width values to exercise saturation and period clamping.
	function automatic logic [31:0] pick_count();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return 32'd0;
		if (roll < 65)
			return $urandom_range(1, 250);
		if (roll < 85)
			return $urandom_range(251, 70000);
		return $urandom();
	endfunction

	// Offers one item, waits for the handshake, and then predicts the result
	// items it causes. valid is left high so that a following item can be
	// offered without a gap.
	task automatic issue_command(input logic [2:0] op, input logic [3:0] idx,
			input logic [31:0] reload_value, input logic [31:0] start_count,
			input logic enable_flag, input logic [2:0] task_type,
			input logic entry_used, input logic typed,
			input logic [15:0] want_period, input logic want_ran);
		ttts_pkg::out_item_t rpt;
		logic                ran;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'b0, entry_used, task_type, enable_flag, start_count,
			reload_value, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);

		fired_slots.delete();
		ran = 1'b0;
		case (op)
			ttts_pkg::OP_EXPIRE: begin
				pending_ticks = cur_period;
				// Bit 32 is the sign of the force counter.
				if (force_cnt[32]) begin
					if (pending_ticks != 16'd0) begin
						run_pass();
						ran = 1'b1;
					end
					force_cnt = {2'b00, mdl_force_reload};
				end else begin
					force_cnt = force_cnt - {17'd0, cur_period};
				end
			end
			ttts_pkg::OP_RUN: begin
				if (pending_ticks != 16'd0) begin
					run_pass();
					ran = 1'b1;
				end
			end
			ttts_pkg::OP_WRITE: begin
				slot_reload[idx]  = reload_value;
				slot_left[idx]    = start_count;
				slot_enabled[idx] = enable_flag;
				slot_type[idx]    = task_type;
				slot_valid[idx]   = entry_used;
				slot_written[idx] = 1'b1;
			end
			ttts_pkg::OP_SET_EN: begin
				slot_enabled[idx] = enable_flag;
			end
			ttts_pkg::OP_RELOAD: begin
				slot_left[idx] = slot_reload[idx];
			end
			default: begin
			end
		endcase

		if (typed) begin
			rpt = '{kind: 1'b1, fired_index: 4'd0, period: want_period,
				pass_ran: want_ran, last: 1'b1};
			awaited_reports.push_back(rpt);
		end else begin
			foreach (fired_slots[k]) begin
				rpt = '{kind: 1'b0, fired_index: fired_slots[k][3:0],
					period: cur_period, pass_ran: ran, last: 1'b0};
				awaited_reports.push_back(rpt);
			end
			rpt = '{kind: 1'b1, fired_index: 4'd0, period: cur_period,
				pass_ran: ran, last: 1'b1};
			awaited_reports.push_back(rpt);
		end
	endtask

	// Stops offering items and waits until every awaited item has come back,
	// then gives the block time to fall idle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Writes both registers on back-to-back edges; the enable stays high in
	// between so that it is never lowered and raised in the same step.
	task automatic apply_settings(input logic [7:0] mask, input logic [30:0] reload);
		cfg_we    <= 1'b1;
		cfg_index <= ttts_pkg::REG_TYPE_MASK;
		cfg_data  <= {23'd0, mask};
		@(posedge clk);
		cfg_index <= ttts_pkg::REG_FORCE_RELOAD;
		cfg_data  <= reload;
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_type_mask    = mask;
		mdl_force_reload = reload;
	endtask

	// Stimulus: reset, the directed table, then random phases with a new
	// register setting in each one.
	initial begin : stimulus
		logic [2:0]  op;
		logic [3:0]  idx;
		logic [31:0] reload_value;
		logic [31:0] start_count;
		logic        enable_flag;
		logic [2:0]  task_type;
		logic        entry_used;
		int          pick;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;

		mdl_type_mask    = ttts_pkg::TYPE_MASK_RESET;
		mdl_force_reload = ttts_pkg::FORCE_RELOAD_RESET;
		for (int i = 0; i < ttts_pkg::MAX_TASKS; i++) begin
			slot_valid[i]   = 1'b0;
			slot_enabled[i] = 1'b0;
			slot_type[i]    = 3'd0;
			slot_reload[i]  = 32'd0;
			slot_left[i]    = 32'd0;
			slot_written[i] = 1'b0;
		end
		pending_ticks = 16'd0;
		cur_period    = ttts_pkg::PERIOD_RESET;
		force_cnt     = {2'b00, ttts_pkg::FORCE_RELOAD_RESET};

		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		foreach (directed_rows[r]) begin
			issue_command(directed_rows[r].op, directed_rows[r].idx,
				directed_rows[r].reload_value, directed_rows[r].start_count,
				directed_rows[r].enable_flag, directed_rows[r].task_type,
				directed_rows[r].entry_used, directed_rows[r].typed,
				directed_rows[r].want_period, directed_rows[r].want_ran);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			// Reset values, then all zeros, then the top force reload with mask 8'h55,
			// then a short force reload so that expiries keep forcing passes, then a random mix.
			case (phase)
				0: apply_settings(ttts_pkg::TYPE_MASK_RESET, ttts_pkg::FORCE_RELOAD_RESET);
				1: apply_settings(8'h00, 31'd0);
				2: apply_settings(8'h55, 31'h7FFF_FFFF);
				3: apply_settings(8'hFF, 31'd2);
				default: apply_settings(8'($urandom_range(0, 255)),
					31'($urandom_range(0, 500)));
			endcase
			steady = (phase == 3);
			if (phase == 2)
				hold_request = 1'b1;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick         = $urandom_range(0, 99);
				idx          = 4'($urandom_range(0, ttts_pkg::MAX_TASKS - 1));
				reload_value = pick_count();
				start_count  = pick_count();
				enable_flag  = ($urandom_range(0, 99) < 80);
				task_type    = 3'($urandom_range(0, 7));
				entry_used   = ($urandom_range(0, 99) < 85);
				// Table updates interleaved with expiries and run
				// requests, so that entries actually count down and fire.
				if (pick < 25)
					op = ttts_pkg::OP_EXPIRE;
				else if (pick < 45)
					op = ttts_pkg::OP_RUN;
				else if (pick < 75)
					op = ttts_pkg::OP_WRITE;
				else if (pick < 85)
					op = ttts_pkg::OP_SET_EN;
				else if (pick < 93)
					op = slot_written[idx] ? ttts_pkg::OP_RELOAD : ttts_pkg::OP_WRITE;
				else
					op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				issue_command(op, idx, reload_value, start_count, enable_flag,
					task_type, entry_used, 1'b0, 16'd0, 1'b0);
			end
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Result side: compares every accepted item with the oldest awaited one
	// and drives tready, idling at random or holding off on request.
	initial begin : result_sink
		ttts_pkg::out_item_t want;
		int                  hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (awaited_reports.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTED)
						$display({"unexpected result item: kind %0d index %0d",
							" period %0d ran %0d last %0d"},
							m_tuser, m_tdata[3:0], m_tdata[19:4], m_tdata[20], m_tlast);
				end else begin
					want = awaited_reports.pop_front();
					if (m_tuser !== want.kind || m_tdata[3:0] !== want.fired_index ||
							m_tdata[19:4] !== want.period || m_tdata[20] !== want.pass_ran ||
							m_tlast !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTED)
							$display({"result mismatch: expected kind %0d index %0d",
								" period %0d ran %0d last %0d, got kind %0d index %0d",
								" period %0d ran %0d last %0d"},
								want.kind, want.fired_index, want.period, want.pass_ran,
								want.last, m_tuser, m_tdata[3:0], m_tdata[19:4],
								m_tdata[20], m_tlast);
					end
				end
			end

			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
